>>> hdl/rpn_packet_filter_evaluator_defines.svh
// Assertion macros for the postfix packet filter evaluator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef RPN_PACKET_FILTER_EVALUATOR_DEFINES_SVH
`define RPN_PACKET_FILTER_EVALUATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RPF_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error(msg);
`define RPF_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error(msg);
`else
`define RPF_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg)
`define RPF_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

>>> hdl/rpf_pkg.sv
// Shared types and constants for the postfix packet filter evaluator.
// No dependencies; used by every module of the block except rpf_ram.
`timescale 1ns / 1ps
package rpf_pkg;

    localparam int VALUE_W         = 48;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int QUEUE_DEPTH     = 4;

    // token codes
    localparam logic [4:0] OP_PUSH     = 5'd0;
    localparam logic [4:0] OP_ADD      = 5'd1;
    localparam logic [4:0] OP_MUL      = 5'd2;
    localparam logic [4:0] OP_SUB      = 5'd3;
    localparam logic [4:0] OP_MOD      = 5'd4;
    localparam logic [4:0] OP_DIV      = 5'd5;
    localparam logic [4:0] OP_EQ       = 5'd6;
    localparam logic [4:0] OP_AND      = 5'd7;
    localparam logic [4:0] OP_OR       = 5'd8;
    localparam logic [4:0] OP_NOT      = 5'd9;
    localparam logic [4:0] OP_IS_IP    = 5'd10;
    localparam logic [4:0] OP_IS_ARP   = 5'd11;
    localparam logic [4:0] OP_IS_UDP   = 5'd12;
    localparam logic [4:0] OP_IS_TCP   = 5'd13;
    localparam logic [4:0] OP_IS_ICMP  = 5'd14;
    localparam logic [4:0] OP_MAC_DST  = 5'd15;
    localparam logic [4:0] OP_MAC_SRC  = 5'd16;
    localparam logic [4:0] OP_ETYPE    = 5'd17;
    localparam logic [4:0] OP_IP_DST   = 5'd18;
    localparam logic [4:0] OP_IP_SRC   = 5'd19;
    localparam logic [4:0] OP_IP_PROTO = 5'd20;
    localparam logic [4:0] OP_UDP_DST  = 5'd21;
    localparam logic [4:0] OP_UDP_SRC  = 5'd22;
    localparam logic [4:0] OP_TCP_DST  = 5'd23;
    localparam logic [4:0] OP_TCP_SRC  = 5'd24;
    localparam logic [4:0] OP_ICMP_TYP = 5'd25;

    localparam logic [15:0] ETH_IP     = 16'h0800;
    localparam logic [15:0] ETH_ARP    = 16'h0806;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNDER    = 3'd1;
    localparam logic [2:0] ST_DIVZERO  = 3'd2;
    localparam logic [2:0] ST_UNKNOWN  = 3'd3;
    localparam logic [2:0] ST_LEFTOVER = 3'd4;
    localparam logic [2:0] ST_OVER     = 3'd5;

    // token classes handed from front to back
    localparam logic [1:0] K_PUSH = 2'd0;
    localparam logic [1:0] K_BIN  = 2'd1;
    localparam logic [1:0] K_NOT  = 2'd2;
    localparam logic [1:0] K_BAD  = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         op;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_token;

endpackage

>>> hdl/rpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/rpf_front.sv
// Front end: token acceptance and classification, header field fetches.
// Depends on rpf_pkg for token codes and the t_token type.
`timescale 1ns / 1ps
module rpf_front (
    input  logic                        start,
    input  logic                        i_full,
    input  logic [4:0]                  i_opcode,
    input  logic [rpf_pkg::VALUE_W-1:0] i_literal,
    input  logic [15:0]                 i_ether_type,
    input  logic [7:0]                  i_ip_proto,
    input  logic [31:0]                 i_ip_src,
    input  logic [31:0]                 i_ip_dst,
    input  logic [15:0]                 i_l4_word0,
    input  logic [15:0]                 i_l4_word1,
    input  logic [47:0]                 i_mac_dst,
    input  logic [47:0]                 i_mac_src,
    input  logic                        i_last_token,
    output logic                        o_busy,
    output logic                        o_push,
    output rpf_pkg::t_token             o_tok
);

    logic is_ip;
    logic is_udp;
    logic is_tcp;
    logic is_icmp;

    assign is_ip   = (i_ether_type == rpf_pkg::ETH_IP);
    assign is_udp  = is_ip && (i_ip_proto == rpf_pkg::PROTO_UDP);
    assign is_tcp  = is_ip && (i_ip_proto == rpf_pkg::PROTO_TCP);
    assign is_icmp = is_ip && (i_ip_proto == rpf_pkg::PROTO_ICMP);

    assign o_busy = i_full;
    assign o_push = start && !i_full;

    always_comb begin
        o_tok.kind  = rpf_pkg::K_PUSH;
        o_tok.op    = i_opcode;
        o_tok.value = '0;
        o_tok.last  = i_last_token;
        unique case (i_opcode) inside
            rpf_pkg::OP_PUSH:     o_tok.value = i_literal;
            [rpf_pkg::OP_ADD:rpf_pkg::OP_OR]: o_tok.kind = rpf_pkg::K_BIN;
            rpf_pkg::OP_NOT:      o_tok.kind = rpf_pkg::K_NOT;
            rpf_pkg::OP_IS_IP:    o_tok.value = {47'd0, is_ip};
            rpf_pkg::OP_IS_ARP:   o_tok.value = {47'd0, i_ether_type == rpf_pkg::ETH_ARP};
            rpf_pkg::OP_IS_UDP:   o_tok.value = {47'd0, is_udp};
            rpf_pkg::OP_IS_TCP:   o_tok.value = {47'd0, is_tcp};
            rpf_pkg::OP_IS_ICMP:  o_tok.value = {47'd0, is_icmp};
            rpf_pkg::OP_MAC_DST:  o_tok.value = i_mac_dst;
            rpf_pkg::OP_MAC_SRC:  o_tok.value = i_mac_src;
            rpf_pkg::OP_ETYPE:
                o_tok.value = {32'd0, is_ip ? rpf_pkg::ETH_IP : rpf_pkg::ETH_ARP};
            rpf_pkg::OP_IP_DST:   o_tok.value = is_ip ? {16'd0, i_ip_dst} : '0;
            rpf_pkg::OP_IP_SRC:   o_tok.value = is_ip ? {16'd0, i_ip_src} : '0;
            rpf_pkg::OP_IP_PROTO: o_tok.value = is_ip ? {40'd0, i_ip_proto} : '0;
            rpf_pkg::OP_UDP_DST:  o_tok.value = is_udp ? {32'd0, i_l4_word1} : '0;
            rpf_pkg::OP_UDP_SRC:  o_tok.value = is_udp ? {32'd0, i_l4_word0} : '0;
            rpf_pkg::OP_TCP_DST:  o_tok.value = is_tcp ? {32'd0, i_l4_word1} : '0;
            rpf_pkg::OP_TCP_SRC:  o_tok.value = is_tcp ? {32'd0, i_l4_word0} : '0;
            // ICMP type is the high byte of the first L4 word
            rpf_pkg::OP_ICMP_TYP:
                o_tok.value = is_icmp ? {40'd0, i_l4_word0[15:8]} : '1;
            default:              o_tok.kind = rpf_pkg::K_BAD;
        endcase
    end

endmodule

>>> hdl/rpf_queue.sv
// Short token queue between the front end and the execution back end.
// Depends on rpf_pkg for the t_token type and the queue depth.
`timescale 1ns / 1ps
module rpf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rpf_pkg::t_token i_tok,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_full,
    output rpf_pkg::t_token o_tok
);

    localparam int PW = $clog2(rpf_pkg::QUEUE_DEPTH);

    rpf_pkg::t_token r_mem [rpf_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   n_wp;
    logic [PW-1:0]   r_rp;
    logic [PW-1:0]   n_rp;
    logic [PW:0]     r_cnt;
    logic [PW:0]     n_cnt;
    logic            do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (PW+1)'(rpf_pkg::QUEUE_DEPTH));
    assign o_tok   = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = i_push ? PW'(r_wp + 1'b1) : r_wp;
        n_rp  = do_pop ? PW'(r_rp + 1'b1) : r_rp;
        n_cnt = r_cnt;
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_tok;
        end
    end

endmodule

>>> hdl/rpf_back.sv
// Back end: operand stack, ALU (16-bit arithmetic, full-width eq/and/or), iterative divider and result report.
// Depends on rpf_pkg, rpf_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "rpn_packet_filter_evaluator_defines.svh"
module rpf_back #(
    parameter int STACK_DEPTH = rpf_pkg::STACK_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tok_valid,
    input  rpf_pkg::t_token i_tok,
    output logic            o_pop,
    output logic            o_done,
    output logic            o_match,
    output logic [2:0]      o_status
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int VW = rpf_pkg::VALUE_W;

    localparam logic [1:0] S_RUN  = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;
    localparam logic [1:0] S_END  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [DW-1:0] r_depth, n_depth;
    logic [2:0]    r_err, n_err;
    logic          r_last, n_last;
    // top two stack entries live in registers, the rest spill to RAM
    logic [VW-1:0] r_tos, n_tos;
    logic [VW-1:0] r_nos, n_nos;
    logic [15:0]   r_rem, n_rem;
    logic [15:0]   r_quo, n_quo;
    logic [15:0]   r_dvsr, n_dvsr;
    logic [3:0]    r_cnt, n_cnt;
    logic          r_is_mod, n_is_mod;
    logic          r_done, n_done;
    logic          r_match, n_match;
    logic [2:0]    r_status, n_status;

    logic [DW-1:0] depth_m2;
    logic [DW-1:0] depth_m3;
    logic          ram_we;
    logic [VW-1:0] ram_rdata;
    logic [15:0]   a16;
    logic [15:0]   b16;
    logic [15:0]   sum16;
    logic [15:0]   dif16;
    logic [15:0]   prod;
    logic [VW-1:0] alu;
    logic [16:0]   shifted;
    logic [16:0]   trial;
    logic          q_bit;
    logic [15:0]   rem_step;
    logic [15:0]   quo_step;

    assign depth_m2 = r_depth - DW'(2);
    assign depth_m3 = r_depth - DW'(3);

    rpf_ram #(
        .WIDTH (VW),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (depth_m2[AW-1:0]),
        .i_wdata (r_nos),
        .i_raddr (depth_m3[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // a is the top value, b the one below it
    assign a16   = r_tos[15:0];
    assign b16   = r_nos[15:0];
    assign sum16 = a16 + b16;
    assign dif16 = a16 - b16;
    assign prod  = a16 * b16;

    always_comb begin
        case (i_tok.op)
            rpf_pkg::OP_ADD: alu = {32'd0, sum16};
            rpf_pkg::OP_MUL: alu = {32'd0, prod};
            rpf_pkg::OP_SUB: alu = {32'd0, dif16};
            rpf_pkg::OP_EQ:  alu = {47'd0, r_tos == r_nos};
            rpf_pkg::OP_AND: alu = r_tos & r_nos;
            rpf_pkg::OP_OR:  alu = r_tos | r_nos;
            default:         alu = '0;
        endcase
    end

    // one restoring division step per cycle
    assign shifted  = {r_rem, r_quo[15]};
    assign trial    = shifted - {1'b0, r_dvsr};
    assign q_bit    = !trial[16];
    assign rem_step = q_bit ? trial[15:0] : shifted[15:0];
    assign quo_step = {r_quo[14:0], q_bit};

    always_comb begin
        n_state  = r_state;
        n_depth  = r_depth;
        n_err    = r_err;
        n_last   = r_last;
        n_tos    = r_tos;
        n_nos    = r_nos;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_dvsr   = r_dvsr;
        n_cnt    = r_cnt;
        n_is_mod = r_is_mod;
        n_done   = 1'b0;
        n_match  = r_match;
        n_status = r_status;
        ram_we   = 1'b0;
        o_pop    = 1'b0;
        unique case (r_state)
            S_RUN: begin
                if (i_tok_valid) begin
                    o_pop   = 1'b1;
                    n_last  = i_tok.last;
                    n_state = i_tok.last ? S_END : S_RUN;
                    // after an error, drop tokens until the last one
                    if (r_err == rpf_pkg::ST_OK) begin
                        unique case (i_tok.kind)
                            rpf_pkg::K_PUSH: begin
                                if (r_depth == DW'(STACK_DEPTH)) begin
                                    n_err = rpf_pkg::ST_OVER;
                                end else begin
                                    ram_we  = (r_depth >= DW'(2));
                                    n_nos   = r_tos;
                                    n_tos   = i_tok.value;
                                    n_depth = r_depth + 1'b1;
                                end
                            end
                            rpf_pkg::K_NOT: begin
                                if (r_depth == '0) begin
                                    n_err = rpf_pkg::ST_UNDER;
                                end else begin
                                    n_tos = {47'd0, r_tos == '0};
                                end
                            end
                            rpf_pkg::K_BIN: begin
                                if (r_depth < DW'(2)) begin
                                    n_err = rpf_pkg::ST_UNDER;
                                end else if (i_tok.op == rpf_pkg::OP_MOD ||
                                             i_tok.op == rpf_pkg::OP_DIV) begin
                                    if (b16 == '0) begin
                                        n_err = rpf_pkg::ST_DIVZERO;
                                    end else begin
                                        n_rem    = '0;
                                        n_quo    = a16;
                                        n_dvsr   = b16;
                                        n_cnt    = '0;
                                        n_is_mod = (i_tok.op == rpf_pkg::OP_MOD);
                                        n_state  = S_DIV;
                                    end
                                end else begin
                                    n_tos   = alu;
                                    n_depth = r_depth - 1'b1;
                                    // refill the second entry from RAM
                                    if (r_depth >= DW'(3)) begin
                                        n_state = S_FILL;
                                    end
                                end
                            end
                            default: n_err = rpf_pkg::ST_UNKNOWN;
                        endcase
                    end
                end
            end
            S_DIV: begin
                n_rem = rem_step;
                n_quo = quo_step;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 4'd15) begin
                    n_tos   = {32'd0, r_is_mod ? rem_step : quo_step};
                    n_depth = r_depth - 1'b1;
                    if (r_depth >= DW'(3)) begin
                        n_state = S_FILL;
                    end else begin
                        n_state = r_last ? S_END : S_RUN;
                    end
                end
            end
            S_FILL: begin
                n_nos   = ram_rdata;
                n_state = r_last ? S_END : S_RUN;
            end
            S_END: begin
                n_done  = 1'b1;
                n_match = (r_err == rpf_pkg::ST_OK) && (r_depth == DW'(1)) &&
                          (r_tos == VW'(1));
                if (r_err != rpf_pkg::ST_OK) begin
                    n_status = r_err;
                end else if (r_depth > DW'(1)) begin
                    n_status = rpf_pkg::ST_LEFTOVER;
                end else begin
                    n_status = rpf_pkg::ST_OK;
                end
                n_depth = '0;
                n_err   = rpf_pkg::ST_OK;
                n_state = S_RUN;
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_depth <= '0;
            r_err   <= rpf_pkg::ST_OK;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_err   <= n_err;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last   <= n_last;
        r_tos    <= n_tos;
        r_nos    <= n_nos;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_dvsr   <= n_dvsr;
        r_cnt    <= n_cnt;
        r_is_mod <= n_is_mod;
        r_match  <= n_match;
        r_status <= n_status;
    end

    assign o_done   = r_done;
    assign o_match  = r_match;
    assign o_status = r_status;

    `RPF_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "result strobe held over two cycles")
    `RPF_ASSERT_IMPLY(a_match_ok, i_clk, i_rst_n, o_done && o_match, o_status == rpf_pkg::ST_OK, "match reported with error status")
    `RPF_ASSERT_IMPLY(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_dvsr != '0, "divider running on zero divisor")
    `RPF_ASSERT_NEXT(a_end_clear, i_clk, i_rst_n, r_state == S_END, r_depth == '0 && r_err == rpf_pkg::ST_OK, "stack not cleared after result")

endmodule

>>> hdl/rpn_packet_filter_evaluator.sv
// Timing: the last token puts the back end in its end state, which registers the result strobe;
// a binary op on a stack deeper than two entries first passes the refill state, which reloads
// the second entry from RAM, and a div or mod first runs the divider (one quotient bit a cycle).
// Throughput: one token per cycle into a four-entry queue, held off by busy while the queue is full.
// Reset: synchronous active-low i_rst_n empties the queue and the stack and clears the error.
// Results cannot be stalled by the receiver: o_done marks a result for exactly one cycle.
`timescale 1ns / 1ps
module rpn_packet_filter_evaluator #(
    parameter int STACK_DEPTH = rpf_pkg::STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  i_opcode,
    input  logic [47:0] i_literal,
    input  logic [15:0] i_ether_type,
    input  logic [7:0]  i_ip_proto,
    input  logic [31:0] i_ip_src,
    input  logic [31:0] i_ip_dst,
    input  logic [15:0] i_l4_word0,
    input  logic [15:0] i_l4_word1,
    input  logic [47:0] i_mac_dst,
    input  logic [47:0] i_mac_src,
    input  logic        i_last_token,
    output logic        o_done,
    output logic        o_match,
    output logic [2:0]  o_status
);

    logic            q_full;
    logic            q_push;
    logic            q_valid;
    logic            q_pop;
    rpf_pkg::t_token f_tok;
    rpf_pkg::t_token q_tok;

    rpf_front u_front (
        .start        (start),
        .i_full       (q_full),
        .i_opcode     (i_opcode),
        .i_literal    (i_literal),
        .i_ether_type (i_ether_type),
        .i_ip_proto   (i_ip_proto),
        .i_ip_src     (i_ip_src),
        .i_ip_dst     (i_ip_dst),
        .i_l4_word0   (i_l4_word0),
        .i_l4_word1   (i_l4_word1),
        .i_mac_dst    (i_mac_dst),
        .i_mac_src    (i_mac_src),
        .i_last_token (i_last_token),
        .o_busy       (busy),
        .o_push       (q_push),
        .o_tok        (f_tok)
    );

    rpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_tok   (f_tok),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_tok   (q_tok)
    );

    rpf_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .i_tok       (q_tok),
        .o_pop       (q_pop),
        .o_done      (o_done),
        .o_match     (o_match),
        .o_status    (o_status)
    );

endmodule

>>> bench/tb.sv
// Self-checking bench for the postfix packet filter evaluator: directed token programs,
// then random programs checked against a predictor of the operand stack and error state.
// Depends on rpf_pkg and rpn_packet_filter_evaluator.
`timescale 1ns / 1ps
module tb;

    localparam int         STK_DEPTH        = rpf_pkg::STACK_DEPTH_DEF;
    localparam int         RANDOM_ITEMS     = 580;
    localparam int         MIN_VERDICTS     = 60;
    localparam int         DRAIN_CYCLES     = 40;
    localparam logic [4:0] OP_LAST_UNKNOWN  = 5'd31;
    localparam logic [47:0] ALL_ONES        = {48{1'b1}};

    typedef struct packed {
        logic [4:0]  op;
        logic [47:0] lit;
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [31:0] ip_src;
        logic [31:0] ip_dst;
        logic [15:0] w0;
        logic [15:0] w1;
        logic [47:0] mac_dst;
        logic [47:0] mac_src;
        logic        fin;
    } t_pkt_token;

    typedef struct packed {
        logic       hit;
        logic [2:0] status;
    } t_verdict;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic [4:0]  i_opcode     = '0;
    logic [47:0] i_literal    = '0;
    logic [15:0] i_ether_type = '0;
    logic [7:0]  i_ip_proto   = '0;
    logic [31:0] i_ip_src     = '0;
    logic [31:0] i_ip_dst     = '0;
    logic [15:0] i_l4_word0   = '0;
    logic [15:0] i_l4_word1   = '0;
    logic [47:0] i_mac_dst    = '0;
    logic [47:0] i_mac_src    = '0;
    logic        i_last_token = 1'b0;
    logic        busy;
    logic        o_done;
    logic        o_match;
    logic [2:0]  o_status;

    // predictor state
    logic [47:0] pred_stack [STK_DEPTH];
    int          pred_depth = 0;
    logic [2:0]  pred_err   = rpf_pkg::ST_OK;

    t_verdict    verdicts [$];
    t_pkt_token  pkt;
    logic        steady    = 1'b0;
    int          n_live    = 0;
    int          n_results = 0;
    int          n_checked = 0;
    int          n_errors  = 0;

    rpn_packet_filter_evaluator DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_literal    (i_literal),
        .i_ether_type (i_ether_type),
        .i_ip_proto   (i_ip_proto),
        .i_ip_src     (i_ip_src),
        .i_ip_dst     (i_ip_dst),
        .i_l4_word0   (i_l4_word0),
        .i_l4_word1   (i_l4_word1),
        .i_mac_dst    (i_mac_dst),
        .i_mac_src    (i_mac_src),
        .i_last_token (i_last_token),
        .o_done       (o_done),
        .o_match      (o_match),
        .o_status     (o_status)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic void stack_push(input logic [47:0] v);
        if (pred_err != rpf_pkg::ST_OK) return;
        if (pred_depth >= STK_DEPTH) begin
            pred_err = rpf_pkg::ST_OVER;
            return;
        end
        pred_stack[pred_depth] = v;
        pred_depth++;
    endfunction

    // a is the top value, b the one below it; arithmetic on the low 16 bits
    function automatic void apply_binary(input logic [4:0] op);
        logic [47:0] a, b, r;
        logic [15:0] a16, b16;
        if (pred_depth < 2) begin
            pred_err = rpf_pkg::ST_UNDER;
            return;
        end
        a = pred_stack[pred_depth - 1];
        b = pred_stack[pred_depth - 2];
        pred_depth -= 2;
        a16 = a[15:0];
        b16 = b[15:0];
        case (op)
            rpf_pkg::OP_ADD: r = {32'd0, 16'(a16 + b16)};
            rpf_pkg::OP_MUL: r = {32'd0, 16'(a16 * b16)};
            rpf_pkg::OP_SUB: r = {32'd0, 16'(a16 - b16)};
            rpf_pkg::OP_MOD, rpf_pkg::OP_DIV: begin
                if (b16 == 16'd0) begin
                    pred_err = rpf_pkg::ST_DIVZERO;
                    return;
                end
                r = {32'd0, (op == rpf_pkg::OP_MOD) ? a16 % b16 : a16 / b16};
            end
            rpf_pkg::OP_EQ:  r = {47'd0, a == b};
            rpf_pkg::OP_AND: r = a & b;
            default: r = a | b;
        endcase
        stack_push(r);
    endfunction

    function automatic void predict_token(input t_pkt_token t);
        logic     is_ip, is_udp, is_tcp, is_icmp;
        t_verdict v;
        if (pred_err == rpf_pkg::ST_OK) begin
            is_ip   = (t.etype == rpf_pkg::ETH_IP);
            is_udp  = is_ip && t.proto == rpf_pkg::PROTO_UDP;
            is_tcp  = is_ip && t.proto == rpf_pkg::PROTO_TCP;
            is_icmp = is_ip && t.proto == rpf_pkg::PROTO_ICMP;
            case (t.op)
                rpf_pkg::OP_PUSH: stack_push(t.lit);
                rpf_pkg::OP_ADD, rpf_pkg::OP_MUL, rpf_pkg::OP_SUB, rpf_pkg::OP_MOD,
                rpf_pkg::OP_DIV, rpf_pkg::OP_EQ, rpf_pkg::OP_AND, rpf_pkg::OP_OR:
                    apply_binary(t.op);
                rpf_pkg::OP_NOT: begin
                    if (pred_depth < 1) begin
                        pred_err = rpf_pkg::ST_UNDER;
                    end else begin
                        pred_depth--;
                        stack_push({47'd0, pred_stack[pred_depth] == 48'd0});
                    end
                end
                rpf_pkg::OP_IS_IP:    stack_push({47'd0, is_ip});
                rpf_pkg::OP_IS_ARP:   stack_push({47'd0, t.etype == rpf_pkg::ETH_ARP});
                rpf_pkg::OP_IS_UDP:   stack_push({47'd0, is_udp});
                rpf_pkg::OP_IS_TCP:   stack_push({47'd0, is_tcp});
                rpf_pkg::OP_IS_ICMP:  stack_push({47'd0, is_icmp});
                rpf_pkg::OP_MAC_DST:  stack_push(t.mac_dst);
                rpf_pkg::OP_MAC_SRC:  stack_push(t.mac_src);
                rpf_pkg::OP_ETYPE:
                    stack_push({32'd0, is_ip ? rpf_pkg::ETH_IP : rpf_pkg::ETH_ARP});
                rpf_pkg::OP_IP_DST:   stack_push(is_ip ? {16'd0, t.ip_dst} : 48'd0);
                rpf_pkg::OP_IP_SRC:   stack_push(is_ip ? {16'd0, t.ip_src} : 48'd0);
                rpf_pkg::OP_IP_PROTO: stack_push(is_ip ? {40'd0, t.proto} : 48'd0);
                rpf_pkg::OP_UDP_DST:  stack_push(is_udp ? {32'd0, t.w1} : 48'd0);
                rpf_pkg::OP_UDP_SRC:  stack_push(is_udp ? {32'd0, t.w0} : 48'd0);
                rpf_pkg::OP_TCP_DST:  stack_push(is_tcp ? {32'd0, t.w1} : 48'd0);
                rpf_pkg::OP_TCP_SRC:  stack_push(is_tcp ? {32'd0, t.w0} : 48'd0);
                rpf_pkg::OP_ICMP_TYP:
                    stack_push(is_icmp ? {40'd0, t.w0[15:8]} : ALL_ONES);
                default:     pred_err = rpf_pkg::ST_UNKNOWN;
            endcase
        end
        if (t.fin) begin
            v.hit    = 1'b0;
            v.status = pred_err;
            if (pred_err == rpf_pkg::ST_OK) begin
                if (pred_depth > 1)
                    v.status = rpf_pkg::ST_LEFTOVER;
                else if (pred_depth == 1 && pred_stack[0] == 48'd1)
                    v.hit = 1'b1;
            end
            verdicts.push_back(v);
            n_results++;
            pred_depth = 0;
            pred_err   = rpf_pkg::ST_OK;
        end
    endfunction

    // ---------------------------------------------------------------- driving

    // Called at a rising edge; returns at the edge that takes the item, start left high.
    task automatic send_token(input t_pkt_token t);
        if (!steady && $urandom_range(99) < 38) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 38);
        end
        start        <= 1'b1;
        i_opcode     <= t.op;
        i_literal    <= t.lit;
        i_ether_type <= t.etype;
        i_ip_proto   <= t.proto;
        i_ip_src     <= t.ip_src;
        i_ip_dst     <= t.ip_dst;
        i_l4_word0   <= t.w0;
        i_l4_word1   <= t.w1;
        i_mac_dst    <= t.mac_dst;
        i_mac_src    <= t.mac_src;
        i_last_token <= t.fin;
        // busy only moves on rising edges, so look at it mid-cycle
        do @(negedge i_clk); while (busy !== 1'b0);
        @(posedge i_clk);
        if (pred_err == rpf_pkg::ST_OK) n_live++;
        predict_token(t);
    endtask

    task automatic emit(input logic [4:0] op, input logic [47:0] lit, input logic fin);
        t_pkt_token t;
        t     = pkt;
        t.op  = op;
        t.lit = lit;
        t.fin = fin;
        send_token(t);
    endtask

    function automatic logic [47:0] rand_literal();
        case ($urandom_range(5))
            0:       return 48'd0;
            1:       return 48'd1;
            2:       return 48'($urandom_range(20));
            3:       return ALL_ONES;
            4:       return {16'($urandom), 32'd0} | 48'($urandom_range(255) << 16);
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [4:0] random_binop();
        return 5'($urandom_range(rpf_pkg::OP_ADD, rpf_pkg::OP_OR));
    endfunction

    task automatic emit_operand(input logic fin);
        if ($urandom_range(1))
            emit(rpf_pkg::OP_PUSH, rand_literal(), fin);
        else
            emit(5'($urandom_range(rpf_pkg::OP_IS_IP, rpf_pkg::OP_ICMP_TYP)),
                 rand_literal(), fin);
    endtask

    task automatic new_packet();
        case ($urandom_range(3))
            0, 1:    pkt.etype = rpf_pkg::ETH_IP;
            2:       pkt.etype = rpf_pkg::ETH_ARP;
            default: pkt.etype = 16'($urandom);
        endcase
        case ($urandom_range(4))
            0:       pkt.proto = rpf_pkg::PROTO_ICMP;
            1:       pkt.proto = rpf_pkg::PROTO_TCP;
            2:       pkt.proto = rpf_pkg::PROTO_UDP;
            default: pkt.proto = 8'($urandom);
        endcase
        pkt.ip_src  = $urandom;
        pkt.ip_dst  = $urandom;
        pkt.w0      = 16'($urandom);
        pkt.w1      = 16'($urandom);
        pkt.mac_dst = 48'({$urandom, $urandom});
        pkt.mac_src = 48'({$urandom, $urandom});
    endtask

    // ---------------------------------------------------------------- checking

    task automatic note_error(input string msg);
        n_errors++;
        if (n_errors <= 10) $display("tb: %s", msg);
    endtask

    always @(posedge i_clk) begin
        t_verdict exp;
        if (i_rst_n && o_done !== 1'b0) begin
            n_checked++;
            if (verdicts.size() == 0) begin
                note_error($sformatf("unexpected result %0d: match=%b status=%0d",
                                     n_checked, o_match, o_status));
            end else begin
                exp = verdicts.pop_front();
                if (o_match !== exp.hit || o_status !== exp.status)
                    note_error($sformatf(
                        "result %0d: expected match=%b status=%0d, got match=%b status=%0d",
                        n_checked, exp.hit, exp.status, o_match, o_status));
            end
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_underflow();
        new_packet();
        emit(rpf_pkg::OP_NOT, '0, 1'b1);
    endtask

    task automatic test_unknown_token();
        emit(OP_LAST_UNKNOWN, ALL_ONES, 1'b1);
    endtask

    // zero low 16 bits under a non-zero high part; later tokens must be ignored
    task automatic test_divide_by_zero();
        emit(rpf_pkg::OP_PUSH, 48'hFFFF_FFFF_0000, 1'b0);
        emit(rpf_pkg::OP_PUSH, ALL_ONES, 1'b0);
        emit(rpf_pkg::OP_DIV, '0, 1'b0);
        emit(rpf_pkg::OP_PUSH, 48'd3, 1'b1);
    endtask

    task automatic test_modulo_by_zero();
        emit(rpf_pkg::OP_PUSH, 48'd0, 1'b0);
        emit(rpf_pkg::OP_PUSH, 48'd9, 1'b0);
        emit(rpf_pkg::OP_MOD, '0, 1'b1);
    endtask

    task automatic test_arithmetic();
        emit(rpf_pkg::OP_PUSH, 48'h0000_0000_FFFF, 1'b0);
        emit(rpf_pkg::OP_PUSH, 48'd1, 1'b0);
        emit(rpf_pkg::OP_ADD, '0, 1'b0);
        emit(rpf_pkg::OP_PUSH, 48'd5, 1'b0);
        emit(rpf_pkg::OP_SUB, '0, 1'b0);
        emit(rpf_pkg::OP_PUSH, 48'd5, 1'b0);
        emit(rpf_pkg::OP_MUL, '0, 1'b0);
        emit(rpf_pkg::OP_PUSH, 48'd100, 1'b0);
        emit(rpf_pkg::OP_DIV, '0, 1'b0);
        emit(rpf_pkg::OP_PUSH, 48'd4, 1'b0);
        emit(rpf_pkg::OP_EQ, '0, 1'b1);
    endtask

    // single value whose low bit is set but is not one
    task automatic test_logic_ops();
        emit(rpf_pkg::OP_PUSH, ALL_ONES, 1'b0);
        emit(rpf_pkg::OP_PUSH, 48'd0, 1'b0);
        emit(rpf_pkg::OP_OR, '0, 1'b0);
        emit(rpf_pkg::OP_PUSH, 48'h8000_0000_0001, 1'b0);
        emit(rpf_pkg::OP_AND, '0, 1'b1);
    endtask

    task automatic test_leftover();
        emit(rpf_pkg::OP_PUSH, 48'd1, 1'b0);
        emit(rpf_pkg::OP_PUSH, 48'd1, 1'b1);
    endtask

    // every fetch on a non-IP packet fills the stack; one more push overflows it
    task automatic test_fetch_overflow();
        pkt.etype   = rpf_pkg::ETH_ARP;
        pkt.proto   = rpf_pkg::PROTO_UDP;
        pkt.ip_src  = '1;
        pkt.ip_dst  = '1;
        pkt.w0      = '1;
        pkt.w1      = '1;
        pkt.mac_dst = ALL_ONES;
        pkt.mac_src = '0;
        for (int k = rpf_pkg::OP_IS_IP; k <= rpf_pkg::OP_ICMP_TYP; k++)
            emit(5'(k), '0, 1'b0);
        emit(rpf_pkg::OP_PUSH, 48'd1, 1'b1);
    endtask

    task automatic random_program();
        int   style, n, pick;
        logic deep;
        new_packet();
        style = $urandom_range(9);
        if (style == 0) begin
            // noise: any code, unknown ones included
            n = $urandom_range(1, 6);
            repeat (n - 1) emit(5'($urandom_range(31)), rand_literal(), 1'b0);
            emit(5'($urandom_range(31)), rand_literal(), 1'b1);
            return;
        end
        deep = (style == 1);
        n = deep ? $urandom_range(STK_DEPTH - 2, STK_DEPTH + 2) : $urandom_range(1, 10);
        for (int k = 0; k < n && pred_err == rpf_pkg::ST_OK; k++) begin
            pick = $urandom_range(99);
            if (!deep && (pred_depth >= STK_DEPTH || (pred_depth >= 2 && pick < 50)))
                emit(pick < 8 ? rpf_pkg::OP_NOT : random_binop(), '0, 1'b0);
            else if (!deep && pred_depth < 2 && pick < 4)
                emit(random_binop(), '0, 1'b0);
            else
                emit_operand(1'b0);
        end
        // fold down to one value, then close the program
        while (pred_err == rpf_pkg::ST_OK && pred_depth > 2) emit(random_binop(), '0, 1'b0);
        if (pred_err != rpf_pkg::ST_OK || pred_depth == 0) begin
            emit_operand(1'b1);
        end else if (pred_depth == 2) begin
            emit($urandom_range(2) == 0 ? rpf_pkg::OP_EQ : random_binop(), '0, 1'b1);
        end else begin
            case ($urandom_range(3))
                0, 1: begin
                    emit(rpf_pkg::OP_PUSH, pred_stack[pred_depth - 1], 1'b0);
                    emit(rpf_pkg::OP_EQ, '0, 1'b1);
                end
                2:       emit(rpf_pkg::OP_NOT, '0, 1'b1);
                default: emit_operand(1'b1);
            endcase
        end
    endtask

    task automatic test_random();
        n_live = 0;
        while (n_live < RANDOM_ITEMS || n_results < MIN_VERDICTS) begin
            // hold start high throughout one stretch of the run
            steady = (n_live >= 250 && n_live < 350);
            random_program();
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_underflow();
        test_unknown_token();
        test_divide_by_zero();
        test_modulo_by_zero();
        test_arithmetic();
        test_logic_ops();
        test_leftover();
        test_fetch_overflow();
        test_random();
        start <= 1'b0;
        while (verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
